@@ rtl/mac_pkg.sv @@
// Shared constants and types for the moving average crossover block.
package mac_pkg;

    localparam int MAX_PERIOD_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;

    localparam int PRICE_W   = 32;
    localparam int AVG_W     = 32;
    localparam int PERIOD_W  = 7;
    localparam int CFG_IDX_W = 8;

    // running sum and divisor widths at the default parameters
    localparam int SUM_W_DEF    = 38;
    localparam int DIVISOR_W_DEF = 7;

    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 7'd10;
    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 7'd20;

    localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD = 8'd1;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } t_trade;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_FAST,
        ST_RD_SLOW,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

@@ rtl/mac_if.sv @@
// Handshake channels of the moving average crossover block.
interface mac_price_if;
    logic                         valid;
    logic                         ready;
    logic [mac_pkg::PRICE_W-1:0]  price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

interface mac_result_if;
    logic                        valid;
    logic                        ready;
    logic [mac_pkg::AVG_W-1:0]   fast_average;
    logic [mac_pkg::AVG_W-1:0]   slow_average;
    logic                        both_ready;
    logic [1:0]                  trade_signal;
    logic                        holding;

    modport source (output valid, output fast_average, output slow_average,
                    output both_ready, output trade_signal, output holding,
                    input ready);
    modport sink   (input valid, input fast_average, input slow_average,
                    input both_ready, input trade_signal, input holding,
                    output ready);
endinterface

interface mac_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mac_pkg::CFG_IDX_W-1:0]  index;
    logic [mac_pkg::PERIOD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mac_ring.sv @@
// Price history memory: one write port, one registered read port.
module mac_ring #(
    parameter int DEPTH  = mac_pkg::MAX_PERIOD_DEF,
    parameter int DATA_W = mac_pkg::PRICE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [DATA_W-1:0]          i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [DATA_W-1:0]          o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/mac_div.sv @@
// Restoring divider, one quotient bit per cycle.
module mac_div #(
    parameter int DIVIDEND_W = mac_pkg::SUM_W_DEF,
    parameter int DIVISOR_W  = mac_pkg::DIVISOR_W_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DIVIDEND_W-1:0]  i_dividend,
    input  logic [DIVISOR_W-1:0]   i_divisor,
    output logic                   o_busy,
    output logic [DIVIDEND_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                   r_busy;
    logic [CNT_W-1:0]       r_cnt;
    logic [DIVISOR_W-1:0]   r_rem;
    logic [DIVIDEND_W-1:0]  r_quo;
    logic [DIVISOR_W-1:0]   r_div;

    logic [DIVISOR_W:0]     w_trial;
    logic                   w_fits;

    // remainder stays below the divisor, so the trial value fits one extra bit
    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVIDEND_W);
        end else if (r_busy) begin
            r_busy <= (r_cnt != CNT_W'(1));
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= DIVISOR_W'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= w_trial[DIVISOR_W-1:0];
            end
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

@@ rtl/moving_average_crossover_core.sv @@
// Top level: dual moving average crossover with ring memory and iterative dividers.
//
//  channel   | dir | handshake            | payload
//  i_price   | in  | valid/ready          | price
//  i_cfg     | in  | valid/ready (always) | index, data (period registers)
//  o_result  | out | valid/ready          | fast_average, slow_average, both_ready,
//            |     |                      | trade_signal, holding
//
// Each item passes through two reads of the single ring read port, a product
// step, then SUM_W steps of the bit-serial dividers. Reset is synchronous;
// history needs no clearing pass, the fill count masks ring entries not yet
// written. A result waits in the output register while the next item is
// taken; a stalled result holds the sequencer in its last state.
module moving_average_crossover_core #(
    parameter int MAX_PERIOD = mac_pkg::MAX_PERIOD_DEF,
    parameter int PRICE_BITS = mac_pkg::PRICE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mac_price_if.sink     i_price,
    mac_cfg_if.sink       i_cfg,
    mac_result_if.source  o_result
);

    localparam int PW = (PRICE_BITS < mac_pkg::PRICE_W) ? PRICE_BITS : mac_pkg::PRICE_W;
    localparam int AW = $clog2(MAX_PERIOD);
    localparam int CW = $clog2(MAX_PERIOD + 1);
    localparam int XW = CW + 1;
    localparam int SW = PW + AW;
    localparam int MW = SW + CW;
    localparam int QW = (SW > mac_pkg::AVG_W) ? SW : mac_pkg::AVG_W;

    mac_pkg::t_state r_state, n_state;

    logic [mac_pkg::PERIOD_W-1:0] r_fast_reg, n_fast_reg;
    logic [mac_pkg::PERIOD_W-1:0] r_slow_reg, n_slow_reg;
    logic [AW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    logic [SW-1:0]  r_fast_sum, n_fast_sum;
    logic [SW-1:0]  r_slow_sum, n_slow_sum;
    logic           r_in_pos, n_in_pos;
    logic [PW-1:0]  r_price, n_price;
    logic [PW-1:0]  r_fold, n_fold;
    logic [MW-1:0]  r_lhs, n_lhs;
    logic [MW-1:0]  r_rhs, n_rhs;

    logic                        r_out_valid, n_out_valid;
    logic [mac_pkg::AVG_W-1:0]   r_out_fast, n_out_fast;
    logic [mac_pkg::AVG_W-1:0]   r_out_slow, n_out_slow;
    logic                        r_out_both, n_out_both;
    mac_pkg::t_trade             r_out_sig, n_out_sig;
    logic                        r_out_hold, n_out_hold;

    logic [CW-1:0]  w_fp, w_sp;
    logic           w_in_acc;
    logic           w_fready, w_sready;

    logic           w_rd_en, w_wr_en;
    logic [AW-1:0]  w_rd_addr;
    logic [PW-1:0]  w_rd_data;
    logic           w_div_start;
    logic           w_fdiv_busy, w_sdiv_busy;
    logic [SW-1:0]  w_fast_quo, w_slow_quo;

    function automatic logic [CW-1:0] eff_period(input logic [mac_pkg::PERIOD_W-1:0] r);
        logic [CW-1:0] p;
        if (r == '0) begin
            p = CW'(1);
        end else if (32'(r) > 32'(MAX_PERIOD)) begin
            p = CW'(MAX_PERIOD);
        end else begin
            p = CW'(r);
        end
        return p;
    endfunction

    // slot written p items ago
    function automatic logic [AW-1:0] back_idx(input logic [AW-1:0] head,
                                               input logic [CW-1:0] p);
        logic [XW-1:0] t;
        t = XW'(head) + XW'(MAX_PERIOD) - XW'(p);
        if (t >= XW'(MAX_PERIOD)) begin
            t = t - XW'(MAX_PERIOD);
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [mac_pkg::AVG_W-1:0] sat_avg(input logic [SW-1:0] q);
        logic [QW-1:0] e;
        e = QW'(q);
        return (e > QW'(32'hFFFF_FFFF)) ? '1 : e[mac_pkg::AVG_W-1:0];
    endfunction

    assign w_fp     = eff_period(r_fast_reg);
    assign w_sp     = eff_period(r_slow_reg);
    assign w_in_acc = i_price.valid && i_price.ready;
    assign w_fready = r_count >= w_fp;
    assign w_sready = r_count >= w_sp;

    assign i_price.ready = (r_state == mac_pkg::ST_IDLE);
    assign i_cfg.ready   = 1'b1;

    assign o_result.valid        = r_out_valid;
    assign o_result.fast_average = r_out_fast;
    assign o_result.slow_average = r_out_slow;
    assign o_result.both_ready   = r_out_both;
    assign o_result.trade_signal = r_out_sig;
    assign o_result.holding      = r_out_hold;

    mac_ring #(
        .DEPTH  (MAX_PERIOD),
        .DATA_W (PW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_head),
        .i_wr_data (r_price),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    mac_div #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (CW)
    ) u_fast_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_fast_sum),
        .i_divisor  (w_fp),
        .o_busy     (w_fdiv_busy),
        .o_quotient (w_fast_quo)
    );

    mac_div #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (CW)
    ) u_slow_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_slow_sum),
        .i_divisor  (w_sp),
        .o_busy     (w_sdiv_busy),
        .o_quotient (w_slow_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fast_reg  = r_fast_reg;
        n_slow_reg  = r_slow_reg;
        n_head      = r_head;
        n_count     = r_count;
        n_fast_sum  = r_fast_sum;
        n_slow_sum  = r_slow_sum;
        n_in_pos    = r_in_pos;
        n_price     = r_price;
        n_fold      = r_fold;
        n_lhs       = r_lhs;
        n_rhs       = r_rhs;
        n_out_valid = r_out_valid;
        n_out_fast  = r_out_fast;
        n_out_slow  = r_out_slow;
        n_out_both  = r_out_both;
        n_out_sig   = r_out_sig;
        n_out_hold  = r_out_hold;
        w_rd_en     = 1'b0;
        w_rd_addr   = back_idx(r_head, w_fp);
        w_wr_en     = 1'b0;
        w_div_start = 1'b0;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        // period write restarts collection (not in ST_RD_SLOW); position flag kept
        if (i_cfg.valid) begin
            if (i_cfg.index == mac_pkg::REG_FAST_PERIOD ||
                i_cfg.index == mac_pkg::REG_SLOW_PERIOD) begin
                if (i_cfg.index == mac_pkg::REG_FAST_PERIOD) begin
                    n_fast_reg = i_cfg.data;
                end else begin
                    n_slow_reg = i_cfg.data;
                end
                n_head     = '0;
                n_count    = '0;
                n_fast_sum = '0;
                n_slow_sum = '0;
            end
        end

        case (r_state)
            mac_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_price = i_price.price[PW-1:0];
                    w_rd_en = 1'b1;
                    n_state = mac_pkg::ST_RD_FAST;
                end
            end
            mac_pkg::ST_RD_FAST: begin
                n_fold    = w_rd_data;
                w_rd_en   = 1'b1;
                w_rd_addr = back_idx(r_head, w_sp);
                n_state   = mac_pkg::ST_RD_SLOW;
            end
            mac_pkg::ST_RD_SLOW: begin
                n_fast_sum = r_fast_sum + SW'(r_price) - (w_fready ? SW'(r_fold) : '0);
                n_slow_sum = r_slow_sum + SW'(r_price) - (w_sready ? SW'(w_rd_data) : '0);
                w_wr_en    = 1'b1;
                n_head     = (r_head == AW'(MAX_PERIOD - 1)) ? '0 : r_head + AW'(1);
                if (r_count < CW'(MAX_PERIOD)) begin
                    n_count = r_count + CW'(1);
                end
                n_state = mac_pkg::ST_MUL;
            end
            mac_pkg::ST_MUL: begin
                n_lhs       = MW'(r_fast_sum) * MW'(w_sp);
                n_rhs       = MW'(r_slow_sum) * MW'(w_fp);
                w_div_start = 1'b1;
                n_state     = mac_pkg::ST_DIV;
            end
            mac_pkg::ST_DIV: begin
                if (!w_fdiv_busy && !w_sdiv_busy) begin
                    n_state = mac_pkg::ST_OUT;
                end
            end
            mac_pkg::ST_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_sig = mac_pkg::SIG_NONE;
                    if (w_fready && w_sready) begin
                        if (r_lhs > r_rhs && !r_in_pos) begin
                            n_out_sig = mac_pkg::SIG_BUY;
                            n_in_pos  = 1'b1;
                        end else if (r_lhs < r_rhs && r_in_pos) begin
                            n_out_sig = mac_pkg::SIG_SELL;
                            n_in_pos  = 1'b0;
                        end
                    end
                    n_out_fast  = w_fready ? sat_avg(w_fast_quo) : '0;
                    n_out_slow  = w_sready ? sat_avg(w_slow_quo) : '0;
                    n_out_both  = w_fready && w_sready;
                    n_out_hold  = n_in_pos;
                    n_out_valid = 1'b1;
                    n_state     = mac_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mac_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_reg  <= mac_pkg::FAST_PERIOD_RST;
            r_slow_reg  <= mac_pkg::SLOW_PERIOD_RST;
            r_head      <= '0;
            r_count     <= '0;
            r_fast_sum  <= '0;
            r_slow_sum  <= '0;
            r_in_pos    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fast_reg  <= n_fast_reg;
            r_slow_reg  <= n_slow_reg;
            r_head      <= n_head;
            r_count     <= n_count;
            r_fast_sum  <= n_fast_sum;
            r_slow_sum  <= n_slow_sum;
            r_in_pos    <= n_in_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_price    <= n_price;
        r_fold     <= n_fold;
        r_lhs      <= n_lhs;
        r_rhs      <= n_rhs;
        r_out_fast <= n_out_fast;
        r_out_slow <= n_out_slow;
        r_out_both <= n_out_both;
        r_out_sig  <= n_out_sig;
        r_out_hold <= n_out_hold;
    end

endmodule
